// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int DEQ_CAPACITY = 64;
    localparam int DEQ_WORD_W   = 32;
    localparam int DEQ_FUNC_W   = 3;
    localparam int DEQ_ERR_W    = 2;

    typedef enum logic [DEQ_FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 3'd0,
        FUNC_PUSH_BACK  = 3'd1,
        FUNC_POP_FRONT  = 3'd2,
        FUNC_POP_BACK   = 3'd3,
        FUNC_PEEK_FRONT = 3'd4,
        FUNC_PEEK_BACK  = 3'd5
    } deq_func_t;

    typedef enum logic [DEQ_ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } deq_err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } deq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } deq_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/deq_in_if.sv -----
// ----------------------------------------------------------------------------
// deq_in_if
// Request channel: operation code and word to push.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_in_if
    import deq_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic [DEQ_FUNC_W-1:0]        func;
    logic signed [DEQ_WORD_W-1:0] push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/deq_out_if.sv -----
// ----------------------------------------------------------------------------
// deq_out_if
// Response channel: word read, error code, count and empty flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_out_if
    import deq_pkg::*;
#(
    parameter int COUNT_W = $clog2(DEQ_CAPACITY + 1)
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DEQ_WORD_W-1:0] read_value;
    logic [DEQ_ERR_W-1:0]         error_code;
    logic [COUNT_W-1:0]           item_count;
    logic                         is_empty;

    modport source (output valid, output read_value, output error_code,
                    output item_count, output is_empty, input ready);
    modport sink   (input valid, input read_value, input error_code,
                    input item_count, input is_empty, output ready);
endinterface

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Ring-buffer deque of signed 32-bit words with push, pop and peek at both ends.
// ----------------------------------------------------------------------------
// Each request beat carries one operation; the block answers it with exactly
// one response beat holding the word read, an error code, the count after the
// operation and an empty flag. Requests are handled one at a time: after the
// accepting edge the block passes through an execute state, in which it makes
// the single access to the slot memory whose read data is registered, and
// offers the response from the next cycle on. req.ready stays low from the
// accept until the response beat has been taken and returns the cycle after,
// so a new request is only taken once the last one has been answered. The
// slot memory needs no clearing after reset; only slots written by earlier
// pushes are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int CAPACITY = DEQ_CAPACITY
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_in_if.sink     req,
    deq_out_if.source  rsp
);

    localparam int PTR_W   = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    deq_cmd_t cmd;

    // The controller only sequences; all state of the queue lives in the
    // datapath, which the controller drives only through the command struct.
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    deq_datapath #(
        .CAPACITY (CAPACITY),
        .PTR_W    (PTR_W),
        .COUNT_W  (COUNT_W)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .req_func       (req.func),
        .req_push_value (req.push_value),
        .rsp_read_value (rsp.read_value),
        .rsp_error_code (rsp.error_code),
        .rsp_item_count (rsp.item_count),
        .rsp_is_empty   (rsp.is_empty)
    );

    // A new request is never taken while a response is still offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request accepted while a response is pending");

    // A full error can only be reported with the queue at capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.error_code == ERR_FULL) |->
            (rsp.item_count == COUNT_W'(CAPACITY)))
        else $error("full error with the queue not at capacity");

    // An empty error leaves an empty queue and returns a zero word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.error_code == ERR_EMPTY) |->
            (rsp.is_empty && rsp.read_value == '0))
        else $error("empty error with stored words or a nonzero word");

    // The count never grows past the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.item_count <= COUNT_W'(CAPACITY)))
        else $error("item count beyond capacity");

    // An accepted request is always followed by its response after the execute state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> ##2 rsp.valid)
        else $error("response not offered after execute");

endmodule

`default_nettype wire

// ----- rtl/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: capture, an execute state, then the response beat.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output deq_cmd_t      cmd
);

    deq_state_t state_reg;
    deq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        rsp_valid   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/deq_datapath.sv -----
// ----------------------------------------------------------------------------
// deq_datapath
// Slot memory, head pointer, occupancy counter and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_datapath
    import deq_pkg::*;
#(
    parameter int CAPACITY = DEQ_CAPACITY,
    parameter int PTR_W    = $clog2(CAPACITY),
    parameter int COUNT_W  = $clog2(CAPACITY + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire deq_cmd_t                     cmd,
    input  wire logic [DEQ_FUNC_W-1:0]        req_func,
    input  wire logic signed [DEQ_WORD_W-1:0] req_push_value,
    output logic signed [DEQ_WORD_W-1:0]      rsp_read_value,
    output logic [DEQ_ERR_W-1:0]              rsp_error_code,
    output logic [COUNT_W-1:0]                rsp_item_count,
    output logic                              rsp_is_empty
);

    localparam int SUM_W = COUNT_W + 1;

    logic signed [DEQ_WORD_W-1:0] slot_mem [CAPACITY];

    deq_func_t                    func_reg;
    logic signed [DEQ_WORD_W-1:0] value_reg;
    logic [PTR_W-1:0]             head_reg;
    logic [PTR_W-1:0]             head_next;
    logic [COUNT_W-1:0]           count_reg;
    logic [COUNT_W-1:0]           count_next;
    deq_err_t                     err_reg;
    deq_err_t                     err_next;
    logic                         hit_reg;
    logic signed [DEQ_WORD_W-1:0] rd_data_reg;

    logic             is_full;
    logic             is_none;
    logic             push_ok;
    logic             read_ok;
    logic [PTR_W-1:0] head_dec;
    logic [PTR_W-1:0] head_inc;
    logic [SUM_W-1:0] sum_tail;
    logic [SUM_W-1:0] sum_back;
    logic [PTR_W-1:0] tail_slot;
    logic [PTR_W-1:0] back_slot;
    logic [PTR_W-1:0] slot_addr;

    assign is_full = (count_reg == COUNT_W'(CAPACITY));
    assign is_none = (count_reg == '0);

    assign head_dec = (head_reg == '0) ? PTR_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == PTR_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;

    // Head plus count stays below twice the capacity, so one subtract wraps it.
    assign sum_tail  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign sum_back  = sum_tail - 1'b1;
    assign tail_slot = (sum_tail >= SUM_W'(CAPACITY)) ?
                       PTR_W'(sum_tail - SUM_W'(CAPACITY)) : PTR_W'(sum_tail);
    assign back_slot = (sum_back >= SUM_W'(CAPACITY)) ?
                       PTR_W'(sum_back - SUM_W'(CAPACITY)) : PTR_W'(sum_back);

    always_comb
    begin
        push_ok    = 1'b0;
        read_ok    = 1'b0;
        slot_addr  = head_reg;
        head_next  = head_reg;
        count_next = count_reg;
        err_next   = ERR_OK;
        case (func_reg)
            FUNC_PUSH_FRONT:
            begin
                push_ok   = !is_full;
                slot_addr = head_dec;
                err_next  = is_full ? ERR_FULL : ERR_OK;
                if (!is_full)
                begin
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_PUSH_BACK:
            begin
                push_ok   = !is_full;
                slot_addr = tail_slot;
                err_next  = is_full ? ERR_FULL : ERR_OK;
                if (!is_full)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_POP_FRONT:
            begin
                read_ok  = !is_none;
                err_next = is_none ? ERR_EMPTY : ERR_OK;
                if (!is_none)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            FUNC_POP_BACK:
            begin
                read_ok   = !is_none;
                slot_addr = back_slot;
                err_next  = is_none ? ERR_EMPTY : ERR_OK;
                if (!is_none)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            FUNC_PEEK_FRONT:
            begin
                read_ok  = !is_none;
                err_next = is_none ? ERR_EMPTY : ERR_OK;
            end
            FUNC_PEEK_BACK:
            begin
                read_ok   = !is_none;
                slot_addr = back_slot;
                err_next  = is_none ? ERR_EMPTY : ERR_OK;
            end
            default:
            begin
                err_next = ERR_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= deq_func_t'(req_func);
            value_reg <= req_push_value;
        end
        if (cmd.execute && push_ok)
        begin
            slot_mem[slot_addr] <= value_reg;
        end
        if (cmd.execute && read_ok)
        begin
            rd_data_reg <= slot_mem[slot_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            err_reg   <= ERR_OK;
            hit_reg   <= 1'b0;
        end
        else if (cmd.execute)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            hit_reg   <= read_ok;
        end
    end

    assign rsp_read_value = hit_reg ? rd_data_reg : '0;
    assign rsp_error_code = err_reg;
    assign rsp_item_count = count_reg;
    assign rsp_is_empty   = (count_reg == '0);

endmodule

`default_nettype wire

// ----- verif/double_ended_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking testbench for the ring-buffer double-ended queue.
// ----------------------------------------------------------------------------
// Request beats go in through the request channel. A shadow deque in the
// bench mirrors every accepted request and works out the response that the
// block owes for it. Each response beat is then compared field by field with
// the oldest answer still owed. The stimulus begins with short directed
// checks on the empty queue and on both ends. Random runs follow: fill and
// drain rounds that reach full capacity, and a long mixed walk over the
// whole range of occupancy. Both channels idle at random outside the no-idle stretches.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    import deq_pkg::*;

    // The request field is three bits wide, so codes 6 and 7 can be sent.
    // The block must treat them as no-ops.
    localparam logic [DEQ_FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [DEQ_FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] WORD_ZERO = 32'h0000_0000;

    localparam int COUNT_W = $clog2(DEQ_CAPACITY + 1);

    // One expected response beat.
    typedef struct {
        logic [DEQ_WORD_W-1:0] word;
        deq_err_t              err;
        logic [COUNT_W-1:0]    count;
        logic                  empty;
    } deq_answer_t;

    logic clk = 1'b0;
    logic rst_n;

    deq_in_if  req_if ();
    deq_out_if rsp_if ();

    double_ended_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow deque. The bench keeps its own copy of the ring contents, the
    // front index and the fill level. These are updated once per accepted
    // request beat, in acceptance order.
    // ------------------------------------------------------------------------
    logic [DEQ_WORD_W-1:0] shadow_slots [DEQ_CAPACITY];
    logic [5:0]            shadow_head  = '0;
    int unsigned           shadow_count = 0;

    deq_answer_t pending_answers [$];
    int unsigned mismatches = 0;

    // When set, neither side inserts idle cycles. This gives stretches in
    // which the block runs at its full rate.
    bit no_idle = 1'b0;

    // Applies one request to the shadow deque and returns the response beat
    // that the block must produce for it.
    function automatic deq_answer_t apply_request(input logic [DEQ_FUNC_W-1:0] op,
                                                  input logic [DEQ_WORD_W-1:0] word);
        deq_answer_t ans;
        logic [5:0]  slot;
        ans.word = '0;
        ans.err  = ERR_OK;
        case (op)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK:
            begin
                if (shadow_count >= DEQ_CAPACITY)
                    ans.err = ERR_FULL;
                else
                begin
                    // A front push steps the head back by one slot and wraps
                    // at the bottom. A back push writes just past the tail.
                    if (op == FUNC_PUSH_FRONT)
                    begin
                        shadow_head = shadow_head - 6'd1;
                        slot        = shadow_head;
                    end
                    else
                        slot = shadow_head + shadow_count[5:0];
                    shadow_slots[slot] = word;
                    shadow_count++;
                end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK, FUNC_PEEK_FRONT, FUNC_PEEK_BACK:
            begin
                if (shadow_count == 0)
                    ans.err = ERR_EMPTY;
                else
                begin
                    if (op == FUNC_POP_FRONT || op == FUNC_PEEK_FRONT)
                        slot = shadow_head;
                    else
                        slot = shadow_head + shadow_count[5:0] - 6'd1;
                    ans.word = shadow_slots[slot];
                    // Popping the last word from the back leaves the head where it is.
                    if (op == FUNC_POP_FRONT)
                    begin
                        shadow_head = shadow_head + 6'd1;
                        shadow_count--;
                    end
                    else if (op == FUNC_POP_BACK)
                        shadow_count--;
                end
            end
            default:
            begin
                // Spare codes leave the deque untouched.
            end
        endcase
        ans.count = shadow_count[COUNT_W-1:0];
        ans.empty = (shadow_count == 0);
        return ans;
    endfunction

    // Length of an idle stretch. Most are zero or short, and a few are long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Random payload word. The two extremes, all ones and zero are each
    // drawn often enough to show up in every run.
    function automatic logic [DEQ_WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return WORD_ONES;
            3: return WORD_ZERO;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DEQ_FUNC_W-1:0] pick_push();
        return $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
    endfunction

    // Read-side operation. About one in five is a peek; the rest are pops.
    function automatic logic [DEQ_FUNC_W-1:0] pick_read();
        case ($urandom_range(0, 9))
            0: return FUNC_PEEK_FRONT;
            1: return FUNC_PEEK_BACK;
            2, 3, 4, 5: return FUNC_POP_FRONT;
            default: return FUNC_POP_BACK;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. An optional idle gap comes first. Then the beat is held
    // until the block takes it. The task returns in the time step of the
    // accepting edge, so valid is either held high for the next beat or
    // lowered by the next call. It never gets both in one step.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [DEQ_FUNC_W-1:0] op,
                                input logic [DEQ_WORD_W-1:0] word);
        int unsigned idle;
        idle = pick_gap();
        if (idle > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= op;
        req_if.push_value <= word;
        do
            @(posedge clk);
        while (!(req_if.valid && req_if.ready));
    endtask

    // Every accepted request beat is run through the shadow deque at once.
    // The expected answers therefore queue up in acceptance order.
    always @(posedge clk)
    begin
        if (rst_n && req_if.valid && req_if.ready)
            pending_answers.push_back(apply_request(req_if.func, req_if.push_value));
    end

    // ------------------------------------------------------------------------
    // Response side. Each accepted beat is checked against the oldest answer
    // owed. After a beat, ready may drop for a random stall.
    // ------------------------------------------------------------------------
    int unsigned rsp_hold = 0;

    always @(posedge clk)
    begin
        deq_answer_t want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_hold = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (rsp_if.read_value !== want.word)
                    begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.word), rsp_if.read_value);
                        mismatches++;
                    end
                    if (rsp_if.error_code !== want.err)
                    begin
                        $error("error_code: expected %0d, got %0d",
                               want.err, rsp_if.error_code);
                        mismatches++;
                    end
                    if (rsp_if.item_count !== want.count)
                    begin
                        $error("item_count: expected %0d, got %0d",
                               want.count, rsp_if.item_count);
                        mismatches++;
                    end
                    if (rsp_if.is_empty !== want.empty)
                    begin
                        $error("is_empty: expected %0d, got %0d",
                               want.empty, rsp_if.is_empty);
                        mismatches++;
                    end
                end
                rsp_hold = pick_gap();
            end
            else if (rsp_hold > 0)
                rsp_hold--;
            rsp_if.ready <= (rsp_hold == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Directed checks.
    // ------------------------------------------------------------------------

    // Every read-side operation on an empty deque must report the empty
    // error. The spare codes must do nothing. The push word is ignored here.
    task automatic test_empty_queue();
        send_request(FUNC_POP_FRONT, WORD_ONES);
        send_request(FUNC_POP_BACK, WORD_MAX);
        send_request(FUNC_PEEK_FRONT, WORD_MIN);
        send_request(FUNC_PEEK_BACK, WORD_ONES);
        send_request(FUNC_SPARE_6, WORD_ONES);
        send_request(FUNC_SPARE_7, WORD_ZERO);
    endtask

    // Extreme words at both ends. The first front push wraps the head below
    // slot zero. Popping the last word empties the deque. The pushes after
    // that start a fresh deque at the head that was kept.
    task automatic test_both_ends();
        send_request(FUNC_PUSH_BACK, WORD_MIN);
        send_request(FUNC_PUSH_FRONT, WORD_MAX);
        send_request(FUNC_PUSH_BACK, WORD_ONES);
        send_request(FUNC_PUSH_FRONT, WORD_ZERO);
        send_request(FUNC_SPARE_7, WORD_ONES);
        send_request(FUNC_PEEK_FRONT, WORD_ZERO);
        send_request(FUNC_PEEK_BACK, WORD_ZERO);
        send_request(FUNC_POP_FRONT, WORD_ZERO);
        send_request(FUNC_POP_BACK, WORD_ZERO);
        send_request(FUNC_POP_FRONT, WORD_ZERO);
        send_request(FUNC_POP_BACK, WORD_ZERO);
        send_request(FUNC_PUSH_BACK, 32'h5A5A_5A5A);
        send_request(FUNC_PEEK_BACK, WORD_ZERO);
        send_request(FUNC_POP_FRONT, WORD_ZERO);
        send_request(FUNC_PUSH_FRONT, 32'hA5A5_A5A5);
        send_request(FUNC_POP_BACK, WORD_ZERO);
    endtask

    // ------------------------------------------------------------------------
    // Random runs.
    // ------------------------------------------------------------------------

    // Each round fills the deque to capacity from random ends, peeks at one
    // end, pushes into the full deque a few times and drains it back to empty.
    // A couple of reads on the empty deque close the round. One round runs
    // with no idling at all.
    task automatic test_fill_and_drain();
        int unsigned           left;
        logic [DEQ_FUNC_W-1:0] op;
        for (int round = 0; round < 4; round++)
        begin
            no_idle = (round == 1);
            for (int i = 0; i < DEQ_CAPACITY; i++)
                send_request(pick_push(), pick_word());
            send_request(pick_read() == FUNC_POP_FRONT ? FUNC_PEEK_FRONT : FUNC_PEEK_BACK,
                         WORD_ZERO);
            repeat ($urandom_range(1, 3))
                send_request(pick_push(), pick_word());
            left = DEQ_CAPACITY;
            while (left > 0)
            begin
                op = pick_read();
                if (op == FUNC_POP_FRONT || op == FUNC_POP_BACK)
                    left--;
                send_request(op, pick_word());
            end
            repeat (2)
                send_request(pick_read(), pick_word());
        end
        no_idle = 1'b0;
    endtask

    // A long mixed walk. The bench keeps a rough fill level of its own and
    // drifts toward a target level that changes now and then. The deque
    // thus spends time near empty, near full and in between. A small share
    // of spare codes is mixed in as noise.
    task automatic test_mixed_walk(input int unsigned beats);
        int unsigned           level;
        int unsigned           target;
        int unsigned           roll;
        logic [DEQ_FUNC_W-1:0] op;
        level  = shadow_count;
        target = DEQ_CAPACITY / 2;
        for (int unsigned n = 0; n < beats; n++)
        begin
            no_idle = ((n / 250) % 4 == 3);
            if (n % 60 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: target = 0;
                    1: target = DEQ_CAPACITY;
                    default: target = $urandom_range(0, DEQ_CAPACITY);
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 2)
                op = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
            else if ($urandom_range(0, 99) < (level < target ? 70 : 30))
                op = pick_push();
            else
                op = pick_read();
            if (op == FUNC_PUSH_FRONT || op == FUNC_PUSH_BACK)
            begin
                if (level < DEQ_CAPACITY)
                    level++;
            end
            else if (op == FUNC_POP_FRONT || op == FUNC_POP_BACK)
            begin
                if (level > 0)
                    level--;
            end
            send_request(op, pick_word());
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.func       = FUNC_PUSH_FRONT;
        req_if.push_value = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_both_ends();
        test_fill_and_drain();
        test_mixed_walk(1100);

        req_if.valid <= 1'b0;
        // One more edge so that the answer for the last accepted beat is
        // already queued before the wait below looks at the queue.
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        // Waiting on a little longer lets any stray response beat show up.
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("PASS double_ended_queue");
        else
            $display("FAIL double_ended_queue");
        $finish;
    end

    // Watchdog. This is far beyond the slowest legal run, in which every
    // beat sees the longest gap on both sides.
    initial
    begin
        #10_000_000;
        $display("FAIL double_ended_queue");
        $finish;
    end

endmodule
